@@ hw/rtl/pwmsplit_pkg.sv @@
// Package with the constants and types of the split high-resolution PWM compare unit.
package pwmsplit_pkg;

   // Field widths.
   localparam int RatioW  = 32;
   localparam int PeriodW = 16;
   localparam int ScaleW  = 8;
   localparam int CoarseW = 16;
   localparam int FineW   = 8;

   // Derived widths of the datapath.
   localparam int ProdW   = PeriodW + ScaleW;          // period * scale
   localparam int HalfW   = RatioW / 2;                // ratio is multiplied in two halves
   localparam int PartW   = ProdW + HalfW;             // one partial product
   localparam int WideW   = ProdW + RatioW + 2;        // doubled product plus rounding bias
   localparam int CountW  = WideW - RatioW;            // total fine step count
   localparam int DivisorW = ScaleW + 1;               // 2 * scale
   localparam int QuotW   = CoarseW;                   // coarse value always fits 16 bits
   localparam int DivBitsPerStage = 2;
   localparam int DivStages = QuotW / DivBitsPerStage;

   // Rounding bias added before the final shift: 2^31 - 1.
   localparam logic [WideW-1:0] RoundBias = WideW'((64'd1 << 31) - 64'd1);

   // Register reset values.
   localparam logic [PeriodW-1:0] PeriodReset = 16'd65520;
   localparam logic [ScaleW-1:0]  ScaleReset  = 8'd151;

   // Configuration register indexes.
   localparam int CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CsrPeriod = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrScale  = 2'd1;

   // Per-item data carried through the division stages.
   typedef struct packed {
      logic [CountW-1:0]   rem;
      logic [QuotW-1:0]    quot;
      logic [ScaleW-1:0]   scale;
   } div_stage_type;

endpackage

@@ hw/rtl/pwm_duty_to_split_hires_compare_unit.sv @@
// Top level of the split high-resolution PWM compare unit.
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  -------------------------------
//  request   start, busy, req_duty_ratio             taken when start and not busy
//  response  rsp_valid, rsp_coarse_a/_b, fine_a/_b   one-cycle strobe, no back-pressure
//  csr       csr_valid, csr_ready, csr_index/wdata   written when valid and ready
//
// One item enters every cycle and passes through these stages: one for the
// period * scale product, one for the two partial products with the ratio, one for the
// rounding add, eight two-bit stages of the restoring divider and the output register.
// Reset clears all valid bits and returns both registers to their defaults.
// Nothing stalls: busy stays low and the receiver takes every result as it appears.
module pwm_duty_to_split_hires_compare_unit
   import pwmsplit_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [RatioW-1:0]    req_duty_ratio,
   output logic                 rsp_valid,
   output logic [CoarseW-1:0]   rsp_coarse_a,
   output logic [FineW-1:0]     rsp_fine_a,
   output logic [CoarseW-1:0]   rsp_coarse_b,
   output logic [FineW-1:0]     rsp_fine_b,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [PeriodW-1:0]   csr_wdata
);

   // Configuration registers.
   logic [PeriodW-1:0] period_ff;
   logic [ScaleW-1:0]  scale_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
         scale_ff  <= ScaleReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrPeriod: period_ff <= csr_wdata;
            CsrScale: begin
               // A zero scale would divide by zero, so it is stored as one.
               if (csr_wdata[ScaleW-1:0] == '0) begin
                  scale_ff <= ScaleW'(1);
               end else begin
                  scale_ff <= csr_wdata[ScaleW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Stage 1: period times scale.
   logic              s1_valid_ff;
   logic [ProdW-1:0]  s1_prod_ff;
   logic [ProdW-1:0]  s1_prod_in;
   logic [RatioW-1:0] s1_ratio_ff;
   logic [ScaleW-1:0] s1_scale_ff;

   assign s1_prod_in = ProdW'(period_ff) * ProdW'(scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_prod_ff  <= s1_prod_in;
      s1_ratio_ff <= req_duty_ratio;
      s1_scale_ff <= scale_ff;
   end

   // Stage 2: the product times each half of the ratio.
   logic              s2_valid_ff;
   logic [PartW-1:0]  s2_lo_ff;
   logic [PartW-1:0]  s2_hi_ff;
   logic [PartW-1:0]  s2_lo_in;
   logic [PartW-1:0]  s2_hi_in;
   logic [ScaleW-1:0] s2_scale_ff;

   assign s2_lo_in = PartW'(s1_prod_ff) * PartW'(s1_ratio_ff[HalfW-1:0]);
   assign s2_hi_in = PartW'(s1_prod_ff) * PartW'(s1_ratio_ff[RatioW-1:HalfW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_lo_ff    <= s2_lo_in;
      s2_hi_ff    <= s2_hi_in;
      s2_scale_ff <= s1_scale_ff;
   end

   // Stage 3: combine, double, round and keep the integer part as the step count.
   logic [WideW-1:0] wide_sum;

   assign wide_sum = ((WideW'(s2_hi_ff) << HalfW) + WideW'(s2_lo_ff)) * WideW'(2)
                     + RoundBias;

   // Division pipeline: entry 0 is loaded by stage 3, each later entry
   // resolves two more quotient bits of count / (2 * scale).
   logic          div_valid_ff [0:DivStages];
   div_stage_type div_ff       [0:DivStages];
   div_stage_type div_in       [1:DivStages];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= s2_valid_ff;
      end
      div_ff[0].rem   <= wide_sum[WideW-1:RatioW];
      div_ff[0].quot  <= '0;
      div_ff[0].scale <= s2_scale_ff;
   end

   for (genvar k = 0; k < DivStages; k++) begin : g_div
      always_comb begin
         logic [CountW-1:0] r;
         logic [QuotW-1:0]  q;
         logic [CountW-1:0] trial;
         r = div_ff[k].rem;
         q = div_ff[k].quot;
         for (int j = 0; j < DivBitsPerStage; j++) begin
            trial = CountW'({div_ff[k].scale, 1'b0}) << (QuotW - 1 - k * DivBitsPerStage - j);
            if (r >= trial) begin
               r = r - trial;
               q[QuotW - 1 - k * DivBitsPerStage - j] = 1'b1;
            end
         end
         div_in[k+1].rem   = r;
         div_in[k+1].quot  = q;
         div_in[k+1].scale = div_ff[k].scale;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         div_ff[k+1] <= div_in[k+1];
      end
   end

   // Output stage: split the remainder between the two channels.
   logic [DivisorW-1:0] rem_final;
   logic [FineW-1:0]    fine_a_in;
   logic [DivisorW-1:0] fine_b_wide;
   logic                carry_b;
   logic [CoarseW-1:0]  coarse_b_in;
   logic [FineW-1:0]    fine_b_in;

   logic               out_valid_ff;
   logic [CoarseW-1:0] coarse_a_ff;
   logic [FineW-1:0]   fine_a_ff;
   logic [CoarseW-1:0] coarse_b_ff;
   logic [FineW-1:0]   fine_b_ff;
   logic [ScaleW-1:0]  out_scale_ff;

   assign rem_final   = div_ff[DivStages].rem[DivisorW-1:0];
   assign fine_a_in   = rem_final[DivisorW-1:1];
   assign fine_b_wide = rem_final - DivisorW'(fine_a_in);
   // When channel B would reach a full coarse count, it takes the carry instead.
   assign carry_b     = (fine_b_wide == DivisorW'(div_ff[DivStages].scale));
   assign coarse_b_in = carry_b ? div_ff[DivStages].quot + CoarseW'(1)
                                : div_ff[DivStages].quot;
   assign fine_b_in   = carry_b ? '0 : fine_b_wide[FineW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid_ff[DivStages];
      end
      coarse_a_ff  <= div_ff[DivStages].quot;
      fine_a_ff    <= fine_a_in;
      coarse_b_ff  <= coarse_b_in;
      fine_b_ff    <= fine_b_in;
      out_scale_ff <= div_ff[DivStages].scale;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_coarse_a = coarse_a_ff;
   assign rsp_fine_a   = fine_a_ff;
   assign rsp_coarse_b = coarse_b_ff;
   assign rsp_fine_b   = fine_b_ff;

`ifndef NO_ASSERTIONS
   // The divider must leave a remainder below the doubled scale.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      div_valid_ff[DivStages] |->
         (div_ff[DivStages].rem < CountW'({div_ff[DivStages].scale, 1'b0})))
      else $error("division remainder not below twice the scale");

   // Both fine counts stay below the scale that came with the item.
   a_fine_below_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fine_a < out_scale_ff) && (rsp_fine_b < out_scale_ff))
      else $error("fine step count not below scale");

   // Channel B is either level with channel A or one coarse count ahead with no fine steps.
   a_carry_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coarse_b == rsp_coarse_a) ||
                    ((rsp_coarse_b == rsp_coarse_a + CoarseW'(1)) && (rsp_fine_b == '0)))
      else $error("channel B carry inconsistent with channel A");
`endif

endmodule

@@ tb/sv/pwm_split_result_check.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares every result of the split high-resolution PWM compare unit.
module pwm_split_result_check
   import pwmsplit_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [RatioW-1:0]    req_duty_ratio,
   input  logic                 rsp_valid,
   input  logic [CoarseW-1:0]   rsp_coarse_a,
   input  logic [FineW-1:0]     rsp_fine_a,
   input  logic [CoarseW-1:0]   rsp_coarse_b,
   input  logic [FineW-1:0]     rsp_fine_b,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [PeriodW-1:0]   csr_wdata,
   output int                   failures,
   output int                   outstanding,
   output int                   results_checked,
   output int                   carries_seen
);

   typedef struct packed {
      logic [RatioW-1:0]  ratio;
      logic [CoarseW-1:0] coarse_a;
      logic [FineW-1:0]   fine_a;
      logic [CoarseW-1:0] coarse_b;
      logic [FineW-1:0]   fine_b;
      logic               carry;
   } split_compare_type;

   logic [PeriodW-1:0] period_reg = PeriodReset;
   logic [ScaleW-1:0]  scale_reg  = ScaleReset;
   split_compare_type  compares_due[$];
   int                 mismatches = 0;

   assign failures = mismatches;

   // Total fine-step count, rounded, then split into a coarse value per channel and two fine halves.
   function automatic split_compare_type split_compare_of(input logic [RatioW-1:0] ratio,
                                                          input logic [PeriodW-1:0] period,
                                                          input logic [ScaleW-1:0] scale);
      split_compare_type res;
      logic [63:0]    wide;
      logic [31:0]    divisor;
      logic [31:0]    count;
      logic [31:0]    coarse;
      logic [31:0]    rem;
      logic [31:0]    fa;
      logic [31:0]    fb;
      logic [31:0]    cb;
      divisor = (scale == '0) ? 32'd1 : 32'(scale);
      // The bias is one short of a half, so exact halves round down.
      wide    = ((64'(period) * 64'(divisor) * 64'(ratio)) << 1) + 64'h7FFF_FFFF;
      count   = wide[63:32];
      coarse  = ((count / divisor) >> 1) & 32'h0000_FFFF;
      rem     = count - ((coarse * divisor) << 1);
      fa      = rem >> 1;
      fb      = rem - fa;
      cb      = coarse;
      res.carry = (fb == divisor);
      if (res.carry) begin
         cb = cb + 32'd1;
         fb = 32'd0;
      end
      res.ratio    = ratio;
      res.coarse_a = coarse[CoarseW-1:0];
      res.fine_a   = fa[FineW-1:0];
      res.coarse_b = cb[CoarseW-1:0];
      res.fine_b   = fb[FineW-1:0];
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [RatioW-1:0] ratio,
                                input logic [31:0] seen, input logic [31:0] wanted);
      $display("[%0t] mismatch on %s: got %0d, wanted %0d (duty ratio %h)",
               $time, what, seen, wanted, ratio);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      split_compare_type want;
      if (reset) begin
         period_reg <= PeriodReset;
         scale_reg  <= ScaleReset;
         compares_due.delete();
      end else begin
         if (rsp_valid) begin
            if (compares_due.size() == 0) begin
               flag_mismatch("result with no item pending", '0, 32'(rsp_coarse_a), '0);
            end else begin
               want = compares_due.pop_front();
               if (rsp_coarse_a !== want.coarse_a)
                  flag_mismatch("coarse_a", want.ratio, 32'(rsp_coarse_a), 32'(want.coarse_a));
               if (rsp_fine_a !== want.fine_a)
                  flag_mismatch("fine_a", want.ratio, 32'(rsp_fine_a), 32'(want.fine_a));
               if (rsp_coarse_b !== want.coarse_b)
                  flag_mismatch("coarse_b", want.ratio, 32'(rsp_coarse_b), 32'(want.coarse_b));
               if (rsp_fine_b !== want.fine_b)
                  flag_mismatch("fine_b", want.ratio, 32'(rsp_fine_b), 32'(want.fine_b));
               results_checked <= results_checked + 1;
            end
         end
         if (start && !busy) begin
            want = split_compare_of(req_duty_ratio, period_reg, scale_reg);
            compares_due.push_back(want);
            if (want.carry)
               carries_seen <= carries_seen + 1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrPeriod: period_reg <= csr_wdata;
               CsrScale: begin
                  // A zero scale is stored as one.
                  scale_reg <= (csr_wdata[ScaleW-1:0] == '0) ? ScaleW'(1) : csr_wdata[ScaleW-1:0];
               end
               default: ;
            endcase
         end
      end
      outstanding <= compares_due.size();
   end

endmodule

@@ tb/sv/tb_pwm_duty_to_split_hires_compare_unit.sv @@
`timescale 1ns / 100ps
// Testbench top for the split high-resolution PWM compare unit: stimulus, clock and verdict.
module tb_pwm_duty_to_split_hires_compare_unit;
   import pwmsplit_pkg::*;

   localparam int CycleLimit  = 300_000;
   localparam int DrainCycles = 14;
   localparam int RandomPhases = 14;
   localparam int PhaseItems  = 125;
   localparam logic [CsrIndexW-1:0] CsrUnusedLo = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrUnusedHi = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [RatioW-1:0]    req_duty_ratio;
   logic                 rsp_valid;
   logic [CoarseW-1:0]   rsp_coarse_a;
   logic [FineW-1:0]     rsp_fine_a;
   logic [CoarseW-1:0]   rsp_coarse_b;
   logic [FineW-1:0]     rsp_fine_b;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [PeriodW-1:0]   csr_wdata;
   int                   failures;
   int                   outstanding;
   int                   results_checked;
   int                   carries_seen;
   int                   cycle_count = 0;
   int                   ratios_sent = 0;
   int                   settings_used = 1;

   pwm_duty_to_split_hires_compare_unit dut (.*);
   pwm_split_result_check result_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // Mostly uniform ratios, with weight on the bottom, the top and powers of two.
   function automatic logic [RatioW-1:0] random_ratio();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) return $urandom;
      if (pick < 14) return $urandom_range(0, 1023);
      if (pick < 17) return 32'hFFFF_FFFF - $urandom_range(0, 1023);
      return (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
   endfunction

   function automatic logic [PeriodW-1:0] random_period();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return 16'hFFFF - 16'($urandom_range(0, 15));
      if (pick == 1) return 16'($urandom_range(0, 255));
      return 16'($urandom);
   endfunction

   // Start stays high when the next item follows at once.
   task automatic send_ratio(input logic [RatioW-1:0] ratio, input int gap);
      start          <= 1'b1;
      req_duty_ratio <= ratio;
      do @(posedge clock); while (busy);
      ratios_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexW-1:0] index, input logic [PeriodW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [PeriodW-1:0] period, input logic [PeriodW-1:0] scale);
      wait_idle();
      write_csr(CsrPeriod, period);
      write_csr(CsrScale, scale);
      settings_used++;
   endtask

   initial begin
      logic [RatioW-1:0] corner_ratios[6] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                              32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000};
      logic [RatioW-1:0] fine_ratios[5]   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0001,
                                              32'h5555_5555, 32'hAAAA_AAAA};
      bit burst;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_duty_ratio <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CsrPeriod;
      csr_wdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values.
      foreach (corner_ratios[k]) send_ratio(corner_ratios[k], k % 3);

      // Writes to indexes that hold no register must change nothing.
      wait_idle();
      write_csr(CsrUnusedLo, 16'hFFFF);
      write_csr(CsrUnusedHi, 16'h0000);
      send_ratio(32'h8000_0000, 0);
      send_ratio(32'hFFFF_FFFF, 1);

      // A zero scale is stored as one, so every odd count carries into channel B.
      apply_setting(16'hFFFF, 16'hFF00);
      foreach (fine_ratios[k]) send_ratio(fine_ratios[k], 0);

      // Zero period gives all-zero results.
      apply_setting(16'h0000, 16'h00FF);
      send_ratio(32'hFFFF_FFFF, 0);
      send_ratio(32'h1234_5678, 2);

      apply_setting(16'hFFFF, 16'h00FF);
      send_ratio(32'hFFFF_FFFF, 0);
      send_ratio(32'h0000_0001, 0);
      send_ratio(32'h0000_0000, 0);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: apply_setting(16'hFFFF, 16'h00FF);
            1: apply_setting(16'h0001, 16'h0001);
            2: apply_setting(16'($urandom_range(1, 7)), 16'($urandom));
            default: apply_setting(random_period(), 16'($urandom));
         endcase
         if (phase % 3 == 1)
            write_csr(($urandom_range(0, 1) == 0) ? CsrUnusedLo : CsrUnusedHi, 16'($urandom));
         burst = (phase % 4 == 2);
         for (int n = 0; n < PhaseItems; n++) begin
            send_ratio(random_ratio(), burst ? 0 : idle_gap());
            if ($urandom_range(0, 149) == 0)
               wait_idle();
         end
      end

      wait_idle();
      $display("Sent %0d duty ratios under %0d register settings; %0d results were compared.",
               ratios_sent, settings_used, results_checked);
      $display("Channel B took a carry from its fine count on %0d of them.", carries_seen);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/pwmsplit_pkg.sv
hw/rtl/pwm_duty_to_split_hires_compare_unit.sv
tb/sv/pwm_split_result_check.sv
tb/sv/tb_pwm_duty_to_split_hires_compare_unit.sv
